// ===== rtl/abelian_block_pattern_matcher_unit_assert.svh =====
// Assertion macros for the abelian block pattern matcher checker.
// Self-contained; taken in by the checker file through `include.
`ifndef ABELIAN_BLOCK_PATTERN_MATCHER_UNIT_ASSERT_SVH
`define ABELIAN_BLOCK_PATTERN_MATCHER_UNIT_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define ABPM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent in the cycle after the antecedent.
`define ABPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/abpm_pkg.sv =====
// Shared constants for the abelian block pattern matcher.
// No dependencies; used by the top level and its checker.
package abpm_pkg;

  localparam int MAX_LETTERS_DEF = 8;
  localparam int COUNT_BITS_DEF  = 8;

  localparam int WORD_W   = 9;
  localparam int COUNTS_W = 56;
  localparam int TOTAL_W  = 3;

  localparam int DATA_W   = 64;
  localparam int ADDR_W   = 5;
  localparam int TDATA_W  = 8;

  // register select, taken from paddr[4:3]
  localparam logic [1:0] REG_PATTERN = 2'd0;
  localparam logic [1:0] REG_ZEROS   = 2'd1;
  localparam logic [1:0] REG_ONES    = 2'd2;
  localparam logic [1:0] REG_TOTAL   = 2'd3;

endpackage

// ===== rtl/abelian_block_pattern_matcher_unit.sv =====
// Abelian block pattern matcher, top level.
// Depends on abpm_pkg.
// Usage
//   Input stream (s_tvalid/s_tready/s_tdata/s_tlast): one binary symbol per
//   item in s_tdata[0]; s_tlast marks the last symbol of a sequence.
//   Output stream (m_tvalid/m_tready/m_tdata): one result item per sequence,
//   m_tdata[0] = matched, m_tdata[1] = bad_pattern.
//   APB port: pattern word at 0x00, zero counts at 0x08, one counts at 0x10,
//   block total at 0x18. Write only while no sequence is in flight.
// Timing
//   One item per clock while s_tready is high. The sequence state updates in
//   the cycle the item is taken; the result of a last symbol sits in the
//   output register in the cycle after acceptance.
// Stall
//   The output register holds its item until m_tready. Input is still taken
//   while it is empty or being drained; only a last symbol that meets a
//   full, stalled output register holds s_tready low.
// Reset
//   rst (synchronous) clears the sequence state and the output valid, and
//   sets the pattern word to 1 and the other registers to 0.
module abelian_block_pattern_matcher_unit #(
  parameter int MAX_LETTERS = abpm_pkg::MAX_LETTERS_DEF,
  parameter int COUNT_BITS  = abpm_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // input stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [abpm_pkg::TDATA_W-1:0] s_tdata,   // [0] symbol, rest zero
  input  logic                        s_tlast,    // final_symbol
  // output stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [abpm_pkg::TDATA_W-1:0] m_tdata,   // [0] matched, [1] bad_pattern
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [abpm_pkg::ADDR_W-1:0] paddr,
  input  logic [abpm_pkg::DATA_W-1:0] pwdata,
  output logic [abpm_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int LP_W  = $clog2(MAX_LETTERS + 1);
  localparam int CNT_W = COUNT_BITS + 1;
  localparam int SUM_W = COUNT_BITS + 2;

  // configuration registers
  logic [abpm_pkg::WORD_W-1:0]   pattern_word;
  logic [abpm_pkg::COUNTS_W-1:0] zero_counts;
  logic [abpm_pkg::COUNTS_W-1:0] one_counts;
  logic [abpm_pkg::TOTAL_W-1:0]  block_total;

  // sequence state
  logic [LP_W-1:0]  letter_position, letter_position_next;
  logic             inside_block, inside_block_next;
  logic [CNT_W-1:0] zeros_seen, zeros_seen_next;
  logic [CNT_W-1:0] ones_seen, ones_seen_next;
  logic             mismatch_seen, mismatch_seen_next;

  logic [MAX_LETTERS:0] word_used;
  logic [LP_W-1:0]      letter_total;
  logic                 bad;
  logic [LP_W-1:0]      block_idx;
  logic [COUNT_BITS-1:0] need0, need1;
  logic                 block_full;
  logic [LP_W-1:0]      pos_inc;
  logic                 symbol;
  logic                 in_accept;
  logic                 cfg_write;
  logic                 ok;

  // ---------------------------------------------------------------------
  // APB: writes on the access phase, reads straight from the registers
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_word <= abpm_pkg::WORD_W'(1);
      zero_counts  <= '0;
      one_counts   <= '0;
      block_total  <= '0;
    end else if (cfg_write) begin
      unique case (paddr[4:3])
        abpm_pkg::REG_PATTERN: pattern_word <= pwdata[abpm_pkg::WORD_W-1:0];
        abpm_pkg::REG_ZEROS:   zero_counts  <= pwdata[abpm_pkg::COUNTS_W-1:0];
        abpm_pkg::REG_ONES:    one_counts   <= pwdata[abpm_pkg::COUNTS_W-1:0];
        abpm_pkg::REG_TOTAL:   block_total  <= pwdata[abpm_pkg::TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      abpm_pkg::REG_PATTERN: prdata = abpm_pkg::DATA_W'(pattern_word);
      abpm_pkg::REG_ZEROS:   prdata = abpm_pkg::DATA_W'(zero_counts);
      abpm_pkg::REG_ONES:    prdata = abpm_pkg::DATA_W'(one_counts);
      abpm_pkg::REG_TOTAL:   prdata = abpm_pkg::DATA_W'(block_total);
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pattern decode: letters sit below the highest set bit
  // ---------------------------------------------------------------------
  assign word_used = pattern_word[MAX_LETTERS:0];

  always_comb begin
    letter_total = '0;
    for (int i = 1; i <= MAX_LETTERS; i++) begin
      if (word_used[i]) letter_total = LP_W'(i);
    end
  end

  assign bad = (word_used <= (MAX_LETTERS + 1)'(1));

  // required counts of the block that follows the current letter
  assign block_idx = letter_position - LP_W'(1);
  assign need0 = COUNT_BITS'(zero_counts >> (32'(block_idx) * COUNT_BITS));
  assign need1 = COUNT_BITS'(one_counts  >> (32'(block_idx) * COUNT_BITS));
  assign block_full = (SUM_W'(zeros_seen) + SUM_W'(ones_seen))
                      >= (SUM_W'(need0) + SUM_W'(need1));

  assign pos_inc = letter_position + LP_W'(1);
  assign symbol  = s_tdata[0];

  // ---------------------------------------------------------------------
  // Next sequence state for one symbol
  // ---------------------------------------------------------------------
  always_comb begin
    letter_position_next = letter_position;
    inside_block_next    = inside_block;
    zeros_seen_next      = zeros_seen;
    ones_seen_next       = ones_seen;
    mismatch_seen_next   = mismatch_seen;
    if (!mismatch_seen) begin
      if (inside_block && !block_full) begin
        // symbol belongs to the block; overshoot kills the match at once
        if (!symbol) begin
          zeros_seen_next = zeros_seen + CNT_W'(1);
          if (zeros_seen_next > CNT_W'(need0)) mismatch_seen_next = 1'b1;
        end else begin
          ones_seen_next = ones_seen + CNT_W'(1);
          if (ones_seen_next > CNT_W'(need1)) mismatch_seen_next = 1'b1;
        end
      end else if (letter_position >= letter_total) begin
        // symbol past the last letter
        mismatch_seen_next = 1'b1;
      end else begin
        if (word_used[letter_position] != symbol) mismatch_seen_next = 1'b1;
        letter_position_next = pos_inc;
        zeros_seen_next      = '0;
        ones_seen_next       = '0;
        if (pos_inc < letter_total) begin
          // a block must follow; it has to be one of the configured ones
          if (4'(letter_position) >= 4'(block_total)) mismatch_seen_next = 1'b1;
          inside_block_next = 1'b1;
        end else begin
          inside_block_next = 1'b0;
        end
      end
    end
  end

  assign ok = !bad && !mismatch_seen_next && !inside_block_next
              && (letter_position_next == letter_total)
              && ((4'(block_total) + 4'd1) == 4'(letter_total));

  // ---------------------------------------------------------------------
  // Handshake: output register acts as the skid stage
  // ---------------------------------------------------------------------
  assign s_tready  = !m_tvalid || m_tready || !s_tlast;
  assign in_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      letter_position <= '0;
      inside_block    <= 1'b0;
      zeros_seen      <= '0;
      ones_seen       <= '0;
      mismatch_seen   <= 1'b0;
    end else if (in_accept) begin
      if (s_tlast) begin
        letter_position <= '0;
        inside_block    <= 1'b0;
        zeros_seen      <= '0;
        ones_seen       <= '0;
        mismatch_seen   <= 1'b0;
      end else begin
        letter_position <= letter_position_next;
        inside_block    <= inside_block_next;
        zeros_seen      <= zeros_seen_next;
        ones_seen       <= ones_seen_next;
        mismatch_seen   <= mismatch_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_accept && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && s_tlast) begin
      m_tdata <= {(abpm_pkg::TDATA_W - 2)'(0), bad, ok};
    end
  end

endmodule

// ===== rtl/abpm_checker.sv =====
// Port-level checker for the abelian block pattern matcher, with its bind.
// Depends on abpm_pkg and abelian_block_pattern_matcher_unit_assert.svh.
`include "abelian_block_pattern_matcher_unit_assert.svh"

module abpm_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         s_tlast,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [abpm_pkg::TDATA_W-1:0] m_tdata
);

  logic in_take;
  logic last_take;
  logic inner_take;
  logic out_stall;
  logic out_bad;

  assign in_take    = s_tvalid && s_tready;
  assign last_take  = in_take && s_tlast;
  assign out_stall  = m_tvalid && !m_tready;
  // inner symbol taken while the output register is free or draining
  assign inner_take = in_take && !s_tlast && !out_stall;
  assign out_bad    = m_tvalid && m_tdata[1];

  // a stalled result item keeps its value
  `ABPM_ASSERT_NEXT(a_out_hold, clk, rst, out_stall, m_tvalid && $stable(m_tdata), "item changed")

  // a bad pattern never matches
  `ABPM_ASSERT_SAME(a_bad_no_match, clk, rst, out_bad, !m_tdata[0], "bad pattern matched")

  // a last symbol yields a result item in the next cycle
  `ABPM_ASSERT_NEXT(a_last_gives_item, clk, rst, last_take, m_tvalid, "no item after last symbol")

  // an inner symbol taken while the output is free or draining brings no result item
  `ABPM_ASSERT_NEXT(a_inner_no_item, clk, rst, inner_take, !m_tvalid, "result after inner symbol")

  // input stalls only behind a waiting result
  `ABPM_ASSERT_SAME(a_stall_cause, clk, rst, !s_tready, out_stall, "input stalled, output free")

endmodule

bind abelian_block_pattern_matcher_unit abpm_checker u_abpm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
